// ===== rtl/lprm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprm_pkg
// shared types, request codes and the prefix mask helper for the
// longest-prefix route match block
// ----------------------------------------------------------------------------
package lprm_pkg;

	localparam int PEER_SLOTS_DEF      = 16;
	localparam int ROUTES_PER_PEER_DEF = 16;
	localparam int IP_W                = 32;
	localparam int LEN_W               = 6;
	localparam int MAX_LEN             = 32;

	// request codes
	localparam logic [1:0] REQ_ROUTE  = 2'd0;
	localparam logic [1:0] REQ_COUNT  = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;
	localparam logic [1:0] REQ_CHECK  = 2'd3;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [3:0]       peer_slot;
		logic [3:0]       route_slot;
		logic [IP_W-1:0]  ip_address;
		logic [LEN_W-1:0] prefix_length;
		logic [4:0]       route_total;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [3:0]       best_peer;
		logic [LEN_W-1:0] best_length;
		logic             source_allowed;
	} rsp_t;

	// one table entry: network is held already masked
	typedef struct packed {
		logic [IP_W-1:0]  network;
		logic [LEN_W-1:0] length;
	} entry_t;

	// mask for a prefix length of at most 32, zero for /0
	function automatic logic [IP_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [IP_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else begin
			m = {IP_W{1'b1}} << (LEN_W'(MAX_LEN) - len);
		end
		return m;
	endfunction

endpackage

// ===== rtl/longest_prefix_route_match_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_route_match_top
// per-peer ipv4 prefix table with route writes, count writes, longest-prefix
// destination lookup and source address check
// ----------------------------------------------------------------------------
//
//   channel  | valid      | stall      | word
//   ---------+------------+------------+-----------------------
//   request  | req_valid  | req_stall  | req  (lprm_pkg::req_t)
//   result   | rsp_valid  | rsp_stall  | rsp  (lprm_pkg::rsp_t)
//
// a route or count write goes from IDLE straight to DONE; a source check scans
//   only its peer's routes, or goes straight to DONE when the peer has no routes
// a lookup scans the routes of every peer in turn, empty peers included,
//   one table entry per cycle through the single read port
// reset clears the route counts only; the route table holds junk until written
// the next request is taken once the last result has moved into the output
//   register, even while that register waits behind rsp_stall
//
module longest_prefix_route_match_top #(
	parameter int PEER_SLOTS      = lprm_pkg::PEER_SLOTS_DEF,
	parameter int ROUTES_PER_PEER = lprm_pkg::ROUTES_PER_PEER_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  lprm_pkg::req_t req,
	output logic           req_stall,
	output logic           rsp_valid,
	output lprm_pkg::rsp_t rsp,
	input  logic           rsp_stall
);

	localparam int DEPTH = PEER_SLOTS * ROUTES_PER_PEER;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// memory port wiring
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	lprm_pkg::entry_t wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	lprm_pkg::entry_t rd_data;

	// engine result handoff
	logic             eng_valid;
	lprm_pkg::rsp_t   eng_rsp;
	logic             take;

	// output register
	logic             out_valid_q;
	lprm_pkg::rsp_t   out_q;

	lprm_route_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lprm_engine #(
		.PEER_SLOTS      (PEER_SLOTS),
		.ROUTES_PER_PEER (ROUTES_PER_PEER)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (eng_valid),
		.rsp       (eng_rsp),
		.rsp_take  (take),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// register is free when empty or being drained this cycle
	assign take = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= eng_valid;
		end
	end

	// result word only loads alongside its valid
	always_ff @(posedge clk) begin
		if (take && eng_valid) begin
			out_q <= eng_rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== rtl/lprm_route_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprm_route_mem
// route entry store: one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module lprm_route_mem #(
	parameter int DEPTH = lprm_pkg::PEER_SLOTS_DEF * lprm_pkg::ROUTES_PER_PEER_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [AW-1:0]           wr_addr,
	input  lprm_pkg::entry_t        wr_data,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output lprm_pkg::entry_t        rd_data
);

	lprm_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/lprm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprm_engine
// request sequencer: count registers, table scan, match compare and
// best-route tracking
// ----------------------------------------------------------------------------
module lprm_engine #(
	parameter int PEER_SLOTS      = lprm_pkg::PEER_SLOTS_DEF,
	parameter int ROUTES_PER_PEER = lprm_pkg::ROUTES_PER_PEER_DEF,
	localparam int DEPTH          = PEER_SLOTS * ROUTES_PER_PEER,
	localparam int AW             = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  lprm_pkg::req_t    req,
	output logic              req_stall,
	output logic              rsp_valid,
	output lprm_pkg::rsp_t    rsp,
	input  logic              rsp_take,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output lprm_pkg::entry_t  wr_data,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  lprm_pkg::entry_t  rd_data
);

	localparam int PW    = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int RW    = (ROUTES_PER_PEER > 1) ? $clog2(ROUTES_PER_PEER) : 1;
	localparam int CW    = $clog2(ROUTES_PER_PEER + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]                    state_q;
	logic [CW-1:0]                 cnt_q [PEER_SLOTS];
	logic                          lookup_q;
	logic [lprm_pkg::IP_W-1:0]     addr_q;
	logic [PW-1:0]                 p_q;
	logic [RW-1:0]                 r_q;
	logic                          vld_s1;
	logic [PW-1:0]                 peer_s1;
	logic                          hit_q;
	logic [PW-1:0]                 bpeer_q;
	logic [lprm_pkg::LEN_W-1:0]    blen_q;
	logic                          allowed_q;

	logic                          accept;
	logic                          peer_ok;
	logic                          route_ok;
	logic [PW-1:0]                 in_peer;
	logic [RW-1:0]                 in_route;
	logic [lprm_pkg::LEN_W-1:0]    len_sat;
	logic [CW-1:0]                 total_sat;
	logic [CW-1:0]                 cur_cnt;
	logic                          last_route;
	logic                          last_peer;
	logic                          s1_match;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);

	assign peer_ok   = (7'(req.peer_slot) < 7'(PEER_SLOTS));
	assign route_ok  = (7'(req.route_slot) < 7'(ROUTES_PER_PEER));
	assign in_peer   = PW'(req.peer_slot);
	assign in_route  = RW'(req.route_slot);
	assign len_sat   = (req.prefix_length > lprm_pkg::LEN_W'(lprm_pkg::MAX_LEN)) ?
		lprm_pkg::LEN_W'(lprm_pkg::MAX_LEN) : req.prefix_length;
	assign total_sat = (7'(req.route_total) > 7'(ROUTES_PER_PEER)) ?
		CW'(ROUTES_PER_PEER) : CW'(req.route_total);

	// route entry write straight from the accepted word
	assign wr_en           = accept && (req.req_type == lprm_pkg::REQ_ROUTE) && peer_ok && route_ok;
	assign wr_addr         = AW'(int'(in_peer) * ROUTES_PER_PEER + int'(in_route));
	assign wr_data.length  = len_sat;
	assign wr_data.network = req.ip_address & lprm_pkg::prefix_mask(len_sat);

	// scan address generation
	assign cur_cnt    = cnt_q[p_q];
	assign last_route = ((CW'(r_q) + CW'(1)) == cur_cnt);
	assign last_peer  = (p_q == PW'(PEER_SLOTS - 1));
	assign rd_en      = (state_q == S_SCAN) && (cur_cnt != '0);
	assign rd_addr    = AW'(int'(p_q) * ROUTES_PER_PEER + int'(r_q));

	// compare stage on the registered read data
	assign s1_match = (addr_q & lprm_pkg::prefix_mask(rd_data.length)) == rd_data.network;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PEER_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept && (req.req_type == lprm_pkg::REQ_COUNT) && peer_ok) begin
			cnt_q[in_peer] <= total_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			vld_s1   <= 1'b0;
			lookup_q <= 1'b0;
			p_q      <= '0;
			r_q      <= '0;
		end else begin
			vld_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lookup_q <= (req.req_type == lprm_pkg::REQ_LOOKUP);
						r_q      <= '0;
						case (req.req_type)
							lprm_pkg::REQ_LOOKUP: begin
								p_q     <= '0;
								state_q <= S_SCAN;
							end
							lprm_pkg::REQ_CHECK: begin
								p_q <= in_peer;
								if (peer_ok && (cnt_q[in_peer] != '0)) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if ((cur_cnt == '0) || last_route) begin
						r_q <= '0;
						if (!lookup_q || last_peer) begin
							state_q <= S_DRAIN;
						end else begin
							p_q <= p_q + PW'(1);
						end
					end else begin
						r_q <= r_q + RW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// address and peer tag of the entry in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= req.ip_address;
		end
		if (rd_en) begin
			peer_s1 <= p_q;
		end
	end

	// best route so far and source verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			bpeer_q   <= '0;
			blen_q    <= '0;
			allowed_q <= 1'b0;
		end else if (accept) begin
			hit_q     <= 1'b0;
			bpeer_q   <= '0;
			blen_q    <= '0;
			allowed_q <= (req.req_type == lprm_pkg::REQ_CHECK) &&
				(!peer_ok || (cnt_q[in_peer] == '0));
		end else if (vld_s1 && s1_match) begin
			if (lookup_q) begin
				if (!hit_q || (rd_data.length > blen_q)) begin
					hit_q   <= 1'b1;
					bpeer_q <= peer_s1;
					blen_q  <= rd_data.length;
				end
			end else begin
				allowed_q <= 1'b1;
			end
		end
	end

	assign rsp_valid          = (state_q == S_DONE);
	assign rsp.hit            = hit_q;
	assign rsp.best_peer      = 4'(bpeer_q);
	assign rsp.best_length    = blen_q;
	assign rsp.source_allowed = allowed_q;

	// no read may still be in flight once the result is shown
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !vld_s1)
		else $error("read in flight at result");

	// reads are only issued while scanning
	a_rd_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == S_SCAN))
		else $error("read outside scan");

	// table writes only on an accepted word
	a_wr_accept: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (req_valid && !req_stall))
		else $error("write without accept");

	// a held result keeps its value until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_take) |=> (rsp_valid && $stable(rsp)))
		else $error("result changed while held");

	// only a lookup can report a hit
	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !lookup_q) |-> !rsp.hit)
		else $error("hit on non-lookup");

endmodule
